FILE: rtl/breakpoint_watchpoint_table_assert.svh
// Assertion macros for the breakpoint/watchpoint table checker.
`ifndef BREAKPOINT_WATCHPOINT_TABLE_ASSERT_SVH
`define BREAKPOINT_WATCHPOINT_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BWT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BWT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/bwt_pkg.sv
// Shared types and codes for the breakpoint/watchpoint table.
`timescale 1ns / 1ps
package bwt_pkg;
  localparam int DEFAULT_SLOTS = 16;

  localparam logic [2:0] OP_ADD_ADDR  = 3'd0;
  localparam logic [2:0] OP_ADD_VALUE = 3'd1;
  localparam logic [2:0] OP_ADD_GUARD = 3'd2;
  localparam logic [2:0] OP_REMOVE    = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_MEMWRITE  = 3'd5;
  localparam logic [2:0] OP_CHECK     = 3'd6;
  localparam logic [2:0] OP_NOP       = 3'd7;

  localparam logic [1:0] KIND_ADDR  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_GUARD = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Request after decode: operation with the entry kind resolved.
  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  target_value;
    logic [7:0]  mem_data;
    logic [15:0] pc;
  } bwt_req_t;

  localparam int REQ_W = $bits(bwt_req_t);

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic       last_valid;
    logic [3:0] last_slot;
  } bwt_res_t;
endpackage

FILE: rtl/bwt_front.sv
// Front end: accepts requests, resolves entry kind for adds, pushes to queue.
`timescale 1ns / 1ps
module bwt_front
  import bwt_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [52:0] in_data,
  output logic        push,
  output bwt_req_t    push_req,
  input  logic        q_full
);
  logic [2:0] op;

  assign op       = in_data[2:0];
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_req.operation    = op;
    push_req.address      = in_data[18:3];
    push_req.target_value = in_data[28:21];
    push_req.mem_data     = in_data[36:29];
    push_req.pc           = in_data[52:37];
    push_req.kind         = in_data[20:19];
    case (op)
      OP_ADD_ADDR:  push_req.kind = KIND_ADDR;
      OP_ADD_VALUE: push_req.kind = KIND_VALUE;
      OP_ADD_GUARD: push_req.kind = KIND_GUARD;
      default:      push_req.kind = in_data[20:19];
    endcase
  end
endmodule

FILE: rtl/bwt_queue.sv
// Two-entry queue between the front end and the slot engine.
`timescale 1ns / 1ps
module bwt_queue
  import bwt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  bwt_req_t push_req,
  output logic     full,
  output logic     not_empty,
  input  logic     pop,
  output bwt_req_t head
);
  bwt_req_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

FILE: rtl/bwt_engine.sv
// Slot engine: walks the table one slot per cycle and produces the result.
`timescale 1ns / 1ps
module bwt_engine
  import bwt_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  bwt_req_t req,
  output logic     pop,
  output logic     res_valid,
  input  logic     res_ready,
  output bwt_res_t res
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LAST = CW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DONE = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  logic [CW-1:0] idx;
  logic [IW-1:0] slot;
  bwt_req_t cur;

  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] fired;
  logic [1:0]  kind_mem [SLOTS];
  logic [15:0] addr_mem [SLOTS];
  logic [7:0]  targ_mem [SLOTS];
  logic [7:0]  shad_mem [SLOTS];

  logic          last_valid;
  logic [IW-1:0] last_slot;
  logic          dup;
  logic          found;
  logic          free_ok;
  logic [IW-1:0] free_slot;
  logic          any_hit;
  logic [1:0]    status;

  logic       s_used;
  logic [1:0] s_kind;
  logic [15:0] s_addr;
  logic [7:0] s_targ;
  logic [7:0] s_shad;
  logic       same;
  logic       match;
  logic       is_add;

  assign slot   = idx[IW-1:0];
  assign s_used = used[slot];
  assign s_kind = kind_mem[slot];
  assign s_addr = addr_mem[slot];
  assign s_targ = targ_mem[slot];
  assign s_shad = shad_mem[slot];
  assign same   = s_used && (s_addr == cur.address) && (s_kind == cur.kind);
  assign is_add = (cur.operation == OP_ADD_ADDR) || (cur.operation == OP_ADD_VALUE)
               || (cur.operation == OP_ADD_GUARD);
  assign pop       = (state == S_IDLE) && req_valid;
  assign res_valid = (state == S_OUT);

  always_comb begin
    case (s_kind)
      KIND_ADDR:  match = (s_addr == cur.pc);
      KIND_VALUE: match = (s_shad == s_targ);
      default:    match = (s_shad != s_targ);
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      if ((cur.operation == OP_MEMWRITE) && s_used && (s_addr == cur.address)) begin
        shad_mem[slot] <= cur.mem_data;
      end
    end
    if ((state == S_DONE) && is_add && !dup && free_ok) begin
      kind_mem[free_slot] <= cur.kind;
      addr_mem[free_slot] <= cur.address;
      shad_mem[free_slot] <= cur.mem_data;
      case (cur.kind)
        KIND_VALUE: targ_mem[free_slot] <= cur.target_value;
        KIND_GUARD: targ_mem[free_slot] <= cur.mem_data;
        default:    targ_mem[free_slot] <= 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      used       <= '0;
      fired      <= '0;
      last_valid <= 1'b0;
      last_slot  <= '0;
      dup        <= 1'b0;
      found      <= 1'b0;
      free_ok    <= 1'b0;
      free_slot  <= '0;
      any_hit    <= 1'b0;
      status     <= ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur     <= req;
            idx     <= '0;
            dup     <= 1'b0;
            found   <= 1'b0;
            free_ok <= 1'b0;
            any_hit <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          case (cur.operation)
            OP_ADD_ADDR, OP_ADD_VALUE, OP_ADD_GUARD: begin
              if (same) begin
                dup <= 1'b1;
              end
              if (!s_used && !free_ok) begin
                free_ok   <= 1'b1;
                free_slot <= slot;
              end
            end
            OP_REMOVE: begin
              if (same && !found) begin
                found       <= 1'b1;
                used[slot]  <= 1'b0;
                fired[slot] <= 1'b0;
                if (last_valid && (last_slot == slot)) begin
                  last_valid <= 1'b0;
                  last_slot  <= '0;
                end
              end
            end
            OP_CLEAR: begin
              used[slot]  <= 1'b0;
              fired[slot] <= 1'b0;
              last_valid  <= 1'b0;
              last_slot   <= '0;
            end
            OP_CHECK: begin
              if (s_used) begin
                if (match) begin
                  if (!fired[slot]) begin
                    fired[slot] <= 1'b1;
                    any_hit     <= 1'b1;
                    last_valid  <= 1'b1;
                    last_slot   <= slot;
                  end
                end else begin
                  fired[slot] <= 1'b0;
                end
              end
            end
            default: begin
            end
          endcase
          if (idx == LAST) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          status <= ST_OK;
          if (is_add) begin
            if (dup) begin
              status <= ST_DUPLICATE;
            end else if (!free_ok) begin
              status <= ST_FULL;
            end else begin
              used[free_slot]  <= 1'b1;
              fired[free_slot] <= 1'b0;
            end
          end else if ((cur.operation == OP_REMOVE) && !found) begin
            status <= ST_NOT_FOUND;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.status     = status;
    res.hit        = any_hit && (cur.operation == OP_CHECK);
    res.last_valid = last_valid;
    res.last_slot  = last_valid ? 4'(last_slot) : 4'd0;
  end
endmodule

FILE: rtl/breakpoint_watchpoint_table.sv
// Top level of the breakpoint/watchpoint table.
// Channels: s_axis carries one request per item (operation, address, kind,
// target byte, memory byte, pc); m_axis returns one result per request
// (status, hit, last-hit valid and slot).
// A front end takes requests into a two-entry queue; the slot engine walks
// all SLOTS slots, one per cycle, then settles status in its done state.
// The engine takes one request at a time; the next leaves the queue only
// after the result of the last one has been taken on m_axis.
// Up to two requests wait in the queue while the engine is busy.
// Reset empties the table, forgets the last hit and empties the queue.
// When m_axis_tready is low the result holds and the engine waits; the queue
// keeps taking requests until it is full.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
module breakpoint_watchpoint_table
  import bwt_pkg::*;
#(
  parameter int SLOTS = DEFAULT_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0], address[18:3], kind[20:19], target_value[28:21],
  // mem_data[36:29], pc[52:37], zero fill[55:53]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], hit[2], last_valid[3], last_slot[7:4]
  output logic [7:0]  m_axis_tdata
);
  logic     push;
  bwt_req_t push_req;
  logic     q_full;
  logic     q_ne;
  logic     pop;
  bwt_req_t head;
  bwt_res_t res;

  bwt_front u_front (
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata[52:0]),
    .push     (push),
    .push_req (push_req),
    .q_full   (q_full)
  );

  bwt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_req  (push_req),
    .full      (q_full),
    .not_empty (q_ne),
    .pop       (pop),
    .head      (head)
  );

  bwt_engine #(.SLOTS(SLOTS)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (q_ne),
    .req       (head),
    .pop       (pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {res.last_slot, res.last_valid, res.hit, res.status};
endmodule

FILE: rtl/bwt_checker.sv
// Port-level checker for the breakpoint/watchpoint table, bound to the top.
`timescale 1ns / 1ps
`include "breakpoint_watchpoint_table_assert.svh"
module bwt_checker
  import bwt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);
  `BWT_ASSERT_IMP(a_slot_zero, clk, rst, m_axis_tvalid && !m_axis_tdata[3],
                  m_axis_tdata[7:4] == 4'd0)
  `BWT_ASSERT_IMP(a_hit_sets_last, clk, rst, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[3])
  `BWT_ASSERT_IMP(a_hit_ok, clk, rst, m_axis_tvalid && m_axis_tdata[2],
                  m_axis_tdata[1:0] == ST_OK)
  `BWT_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind breakpoint_watchpoint_table bwt_checker u_bwt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/breakpoint_watchpoint_table_test.sv
// Stream-level testbench for the breakpoint/watchpoint table.
`timescale 1ns / 1ps
module breakpoint_watchpoint_table_test
  import bwt_pkg::*;
();

  localparam int NSLOT = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  breakpoint_watchpoint_table #(.SLOTS(NSLOT)) u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Table copy kept by the testbench.
  logic        tbl_used [NSLOT];
  logic [1:0]  tbl_kind [NSLOT];
  logic [15:0] tbl_addr [NSLOT];
  logic [7:0]  tbl_target [NSLOT];
  logic [7:0]  tbl_shadow [NSLOT];
  logic        tbl_fired [NSLOT];
  logic        hit_known;
  logic [3:0]  hit_slot;

  logic [7:0]  pending_results [$];
  int          mismatches = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  bit          hold_recv = 1'b0;

  // Watched addresses kept few so memory writes and checks find entries.
  logic [15:0] hot_addr [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h8001};

  function automatic logic [1:0] table_add(logic [1:0] k, logic [15:0] a,
                                           logic [7:0] tv, logic [7:0] md);
    for (int i = 0; i < NSLOT; i++)
      if (tbl_used[i] && tbl_addr[i] == a && tbl_kind[i] == k) return ST_DUPLICATE;
    for (int i = 0; i < NSLOT; i++) begin
      if (!tbl_used[i]) begin
        tbl_used[i] = 1'b1;
        tbl_kind[i] = k;
        tbl_addr[i] = a;
        tbl_fired[i] = 1'b0;
        tbl_shadow[i] = md;
        tbl_target[i] = (k == KIND_VALUE) ? tv : (k == KIND_GUARD) ? md : 8'd0;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic logic [7:0] table_result(logic [55:0] req);
    logic [2:0]  op;
    logic [15:0] a;
    logic [1:0]  k;
    logic [7:0]  tv;
    logic [7:0]  md;
    logic [15:0] pc;
    logic [1:0]  st;
    logic        any;
    logic        m;
    op = req[2:0]; a = req[18:3]; k = req[20:19];
    tv = req[28:21]; md = req[36:29]; pc = req[52:37];
    st = ST_OK;
    any = 1'b0;
    case (op)
      OP_ADD_ADDR:  st = table_add(KIND_ADDR, a, tv, md);
      OP_ADD_VALUE: st = table_add(KIND_VALUE, a, tv, md);
      OP_ADD_GUARD: st = table_add(KIND_GUARD, a, tv, md);
      OP_REMOVE: begin
        st = ST_NOT_FOUND;
        for (int i = 0; i < NSLOT; i++) begin
          if (st == ST_NOT_FOUND && tbl_used[i] && tbl_addr[i] == a && tbl_kind[i] == k) begin
            if (hit_known && hit_slot == i) begin
              hit_known = 1'b0;
              hit_slot = '0;
            end
            tbl_used[i] = 1'b0;
            tbl_fired[i] = 1'b0;
            st = ST_OK;
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) begin
          tbl_used[i] = 1'b0;
          tbl_fired[i] = 1'b0;
        end
        hit_known = 1'b0;
        hit_slot = '0;
      end
      OP_MEMWRITE: begin
        for (int i = 0; i < NSLOT; i++)
          if (tbl_used[i] && tbl_addr[i] == a) tbl_shadow[i] = md;
      end
      OP_CHECK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (tbl_used[i]) begin
            if (tbl_kind[i] == KIND_ADDR) m = (tbl_addr[i] == pc);
            else if (tbl_kind[i] == KIND_VALUE) m = (tbl_shadow[i] == tbl_target[i]);
            else m = (tbl_shadow[i] != tbl_target[i]);
            if (m) begin
              if (!tbl_fired[i]) begin
                tbl_fired[i] = 1'b1;
                any = 1'b1;
                hit_known = 1'b1;
                hit_slot = i[3:0];
              end
            end else begin
              tbl_fired[i] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return {hit_known ? hit_slot : 4'd0, hit_known, any, st};
  endfunction

  // Valid stays high between back-to-back requests; drop it only for a gap.
  task automatic send_request(logic [2:0] op, logic [15:0] a, logic [1:0] k,
                              logic [7:0] tv, logic [7:0] md, logic [15:0] pc);
    logic [55:0] req;
    req = {3'b000, pc, md, tv, k, a, op};
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tdata <= req;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(table_result(req));
  endtask

  function automatic logic [15:0] pick_addr();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : hot_addr[$urandom_range(0, 3)];
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) send_request(OP_ADD_ADDR, pick_addr(), 2'($urandom), 8'($urandom),
                             8'($urandom), 16'($urandom));
    else if (r < 24) send_request(OP_ADD_VALUE, pick_addr(), 2'($urandom),
                                  8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                                  16'($urandom));
    else if (r < 34) send_request(OP_ADD_GUARD, pick_addr(), 2'($urandom), 8'($urandom),
                                  8'($urandom_range(0, 3)), 16'($urandom));
    else if (r < 44) send_request(OP_REMOVE, pick_addr(), 2'($urandom), 8'($urandom),
                                  8'($urandom), 16'($urandom));
    else if (r < 46) send_request(OP_CLEAR, 16'($urandom), 2'($urandom), 8'($urandom),
                                  8'($urandom), 16'($urandom));
    else if (r < 68) send_request(OP_MEMWRITE, pick_addr(), 2'($urandom), 8'($urandom),
                                  8'($urandom_range(0, 3)), 16'($urandom));
    else if (r < 98) send_request(OP_CHECK, 16'($urandom), 2'($urandom), 8'($urandom),
                                  8'($urandom), $urandom_range(0, 1) ? pick_addr()
                                                                     : 16'($urandom));
    else send_request(OP_NOP, 16'($urandom), 2'($urandom), 8'($urandom),
                      8'($urandom), 16'($urandom));
  endtask

  // Receiver: random stalls, plus a long hold-off when asked.
  initial begin
    @(negedge rst);
    forever begin
      if (hold_recv) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_recv = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (want[1:0] !== m_axis_tdata[1:0] || want[2] !== m_axis_tdata[2] ||
            want[3] !== m_axis_tdata[3] || want[7:4] !== m_axis_tdata[7:4]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: status %0d/%0d hit %0d/%0d last %0d:%0d/%0d:%0d",
                     want[1:0], m_axis_tdata[1:0], want[2], m_axis_tdata[2],
                     want[3], want[7:4], m_axis_tdata[3], m_axis_tdata[7:4]);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(OP_REMOVE, 16'h0000, KIND_ADDR, 8'h00, 8'h00, 16'h0000);
    send_request(OP_ADD_ADDR, 16'hFFFF, KIND_NONE, 8'hFF, 8'hFF, 16'hFFFF);
    send_request(OP_ADD_ADDR, 16'hFFFF, KIND_ADDR, 8'h00, 8'h00, 16'h0000);
    send_request(OP_ADD_VALUE, 16'h0000, KIND_VALUE, 8'hFF, 8'h00, 16'h0000);
    send_request(OP_ADD_GUARD, 16'h0000, KIND_GUARD, 8'h00, 8'h55, 16'h0000);
    send_request(OP_CHECK, 16'h0000, KIND_ADDR, 8'h00, 8'h00, 16'hFFFF);
    send_request(OP_CHECK, 16'h0000, KIND_ADDR, 8'h00, 8'h00, 16'hFFFF);
    send_request(OP_MEMWRITE, 16'h0000, KIND_ADDR, 8'h00, 8'hFF, 16'h0000);
    send_request(OP_CHECK, 16'hFFFF, KIND_NONE, 8'hFF, 8'hFF, 16'h0000);
    send_request(OP_MEMWRITE, 16'h0000, KIND_ADDR, 8'h00, 8'h55, 16'h0000);
    send_request(OP_CHECK, 16'h0000, KIND_ADDR, 8'h00, 8'h00, 16'h0000);
    send_request(OP_REMOVE, 16'h0000, KIND_VALUE, 8'h00, 8'h00, 16'h0000);
    send_request(OP_REMOVE, 16'hFFFF, KIND_NONE, 8'h00, 8'h00, 16'h0000);
    send_request(OP_NOP, 16'hFFFF, KIND_NONE, 8'hFF, 8'hFF, 16'hFFFF);
    // Fill the table, then overflow it.
    for (int i = 0; i < 15; i++)
      send_request(OP_ADD_ADDR, 16'(i + 16), KIND_ADDR, 8'h00, 8'h00, 16'h0000);
    send_request(OP_ADD_VALUE, 16'h4242, KIND_VALUE, 8'h00, 8'h00, 16'h0000);
    send_request(OP_CHECK, 16'h0000, KIND_ADDR, 8'h00, 8'h00, 16'd30);
    send_request(OP_CLEAR, 16'h0000, KIND_ADDR, 8'h00, 8'h00, 16'h0000);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      send_random();
      if (n % 60 == 59)
        send_request(OP_CLEAR, 16'h0000, KIND_ADDR, 8'h00, 8'h00, 16'h0000);
    end
  endtask

  task automatic test_backpressure();
    hold_recv = 1'b1;
    for (int n = 0; n < 12; n++) send_random();
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tbl_used[i] = 1'b0;
      tbl_fired[i] = 1'b0;
      tbl_kind[i] = '0;
      tbl_addr[i] = '0;
      tbl_target[i] = '0;
      tbl_shadow[i] = '0;
    end
    hit_known = 1'b0;
    hit_slot = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_random(100);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/bwt_pkg.sv
rtl/bwt_front.sv
rtl/bwt_queue.sv
rtl/bwt_engine.sv
rtl/breakpoint_watchpoint_table.sv
rtl/bwt_checker.sv
verif/breakpoint_watchpoint_table_test.sv
